@@ rtl/psc_pkg.sv @@
// package for the paired sample covariance unit
// transaction payload types and fixed field widths, no dependencies
package psc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COV_W       = 32;
   localparam int COUNT_OUT_W = 11;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
      logic                       last;
   } psc_req_type;

   typedef struct packed {
      logic signed [COV_W-1:0]   covariance;
      logic [COUNT_OUT_W-1:0]    sample_count;
      logic                      overflow;
   } psc_rsp_type;

   typedef struct packed {
      logic acc;
      logic mul_init;
      logic mul_step;
      logic sub;
      logic div_step;
      logic load_out;
   } psc_cmd_type;

endpackage

@@ rtl/psc_ctrl.sv @@
// controller for the paired sample covariance unit
// sequences accumulation, serial multiply and restoring divide; uses psc_pkg
module psc_ctrl #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output psc_pkg::psc_cmd_type cmd
);
   import psc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int LOG_W  = $clog2(MAX_SAMPLES);
   localparam int SXY_W  = 2 * SAMPLE_W + LOG_W;
   localparam int DIFF_W = SXY_W + CNT_W + 1;
   localparam int ITER_W = $clog2(DIFF_W);

   localparam logic [2:0] ST_ACCUM = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SUB   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready = (state_ff == ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.acc  = accept;
      unique case (state_ff)
         ST_ACCUM: begin
            if (accept && req_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.mul_init = 1'b1;
            step_in      = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == ITER_W'(CNT_W - 1)) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == ITER_W'(DIFF_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/psc_datapath.sv @@
// datapath for the paired sample covariance unit
// running sums, shift-add multiplier, restoring divider, result register; uses psc_pkg
module psc_datapath #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psc_pkg::psc_cmd_type cmd,
   input  psc_pkg::psc_req_type req_data,
   output psc_pkg::psc_rsp_type rsp_data
);
   import psc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int LOG_W  = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = SAMPLE_W + LOG_W;
   localparam int SXY_W  = 2 * SAMPLE_W + LOG_W;
   localparam int DIFF_W = SXY_W + CNT_W + 1;
   localparam int NN_W   = 2 * CNT_W;

   // running sums
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic signed [SXY_W-1:0] sum_xy_ff, sum_xy_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    drop_ff, drop_in;
   logic signed [2*SAMPLE_W-1:0] pair_prod;
   logic                    room;

   // finishing arithmetic
   logic signed [DIFF_W-1:0]  acc_ff, mcand_ff;
   logic [CNT_W-1:0]          nsh_ff;
   logic signed [2*SUM_W-1:0] sxsy_ff;
   logic [NN_W-1:0]           nn_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic                      neg_ff;
   logic [DIFF_W-1:0]         quo_ff;
   logic [NN_W-1:0]           rem_ff;
   logic [NN_W:0]             trial;
   logic                      q_bit;
   logic [COV_W-1:0]          quo_low;
   psc_rsp_type               rsp_ff;

   assign pair_prod = req_data.sample_x * req_data.sample_y;
   assign room      = (count_ff < CNT_W'(MAX_SAMPLES));

   always_comb begin
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xy_in = sum_xy_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      if (cmd.load_out) begin
         sum_x_in  = '0;
         sum_y_in  = '0;
         sum_xy_in = '0;
         count_in  = '0;
         drop_in   = 1'b0;
      end else if (cmd.acc) begin
         if (room) begin
            sum_x_in  = sum_x_ff + SUM_W'(req_data.sample_x);
            sum_y_in  = sum_y_ff + SUM_W'(req_data.sample_y);
            sum_xy_in = sum_xy_ff + SXY_W'(pair_prod);
            count_in  = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xy_ff <= '0;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
      end else begin
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xy_ff <= sum_xy_in;
         count_ff  <= count_in;
         drop_ff   <= drop_in;
      end
   end

   assign diff    = acc_ff - DIFF_W'(sxsy_ff);
   assign trial   = {rem_ff, quo_ff[DIFF_W-1]};
   assign q_bit   = (trial >= {1'b0, nn_ff});
   assign quo_low = quo_ff[COV_W-1:0];

   // n*Sxy by shift-add over the bits of n, then |diff| / (n*n) one bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.mul_init) begin
         acc_ff   <= '0;
         mcand_ff <= DIFF_W'(sum_xy_ff);
         nsh_ff   <= count_ff;
         sxsy_ff  <= sum_x_ff * sum_y_ff;
         nn_ff    <= NN_W'(count_ff) * NN_W'(count_ff);
      end
      if (cmd.mul_step) begin
         if (nsh_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff <= mcand_ff <<< 1;
         nsh_ff   <= nsh_ff >> 1;
      end
      if (cmd.sub) begin
         neg_ff <= diff[DIFF_W-1];
         quo_ff <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (q_bit) begin
            rem_ff <= NN_W'(trial - {1'b0, nn_ff});
         end else begin
            rem_ff <= trial[NN_W-1:0];
         end
         quo_ff <= {quo_ff[DIFF_W-2:0], q_bit};
      end
      if (cmd.load_out) begin
         rsp_ff.covariance   <= neg_ff ? -quo_low : quo_low;
         rsp_ff.sample_count <= COUNT_OUT_W'(count_ff);
         rsp_ff.overflow     <= drop_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/paired_sample_covariance_unit.sv @@
// Paired sample population covariance. One (x, y) pair is taken per clock while
// a set accumulates; after the pair flagged last the unit stops taking pairs
// while the shift-add multiplier forms n*Sxy one bit of n per cycle and the
// restoring divider forms the quotient one bit per cycle; once any earlier
// result has been taken it loads the result register and takes pairs again
// while the new result waits. Pairs beyond MAX_SAMPLES are dropped and flagged.
// top level: controller and datapath; uses psc_pkg
module paired_sample_covariance_unit #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  psc_pkg::psc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output psc_pkg::psc_rsp_type rsp_data
);
   import psc_pkg::*;

   psc_cmd_type cmd;

   psc_ctrl #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   psc_datapath #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ verif/tb.sv @@
// testbench for paired_sample_covariance_unit: random and directed sample sets,
// covariance predicted per set by a scoreboard class and checked field by field
// depends on rtl/psc_pkg.sv and rtl/paired_sample_covariance_unit.sv
`timescale 1ns / 1ps

module tb;
   import psc_pkg::*;

   localparam int MAX_PAIRS    = 1024;
   localparam int SETTLE_TICKS = 200;

   typedef enum int {FULL_RANGE, EXTREMES, NEAR_ZERO} sample_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   psc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   psc_rsp_type rsp_data;

   int unsigned send_idle_pct = 30;
   int unsigned recv_idle_pct = 80;

   class covariance_scoreboard_type;
      longint      sum_x;
      longint      sum_y;
      longint      sum_xy;
      int unsigned pairs;
      bit          dropped;
      psc_rsp_type expected_covariances[$];
      int unsigned mismatches;

      function new();
         clear_sums();
         mismatches = 0;
      endfunction

      function void clear_sums();
         sum_x   = 0;
         sum_y   = 0;
         sum_xy  = 0;
         pairs   = 0;
         dropped = 1'b0;
      endfunction

      function void accumulate_pair(psc_req_type item);
         longint      x;
         longint      y;
         longint      n;
         longint      diff;
         psc_rsp_type result;
         x = $signed(item.sample_x);
         y = $signed(item.sample_y);
         if (pairs < MAX_PAIRS) begin
            sum_x  += x;
            sum_y  += y;
            sum_xy += x * y;
            pairs++;
         end else begin
            dropped = 1'b1;
         end
         if (!item.last) return;
         n    = pairs;
         diff = n * sum_xy - sum_x * sum_y;
         result.covariance   = 32'(diff / (n * n));
         result.sample_count = 11'(pairs);
         result.overflow     = dropped;
         expected_covariances.push_back(result);
         clear_sums();
      endfunction

      function void check_result(psc_rsp_type got);
         psc_rsp_type want;
         if (expected_covariances.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual cov %0d count %0d ovf %0b",
                     $time, got.covariance, got.sample_count, got.overflow);
            mismatches++;
            return;
         end
         want = expected_covariances.pop_front();
         if (got.covariance !== want.covariance) begin
            $display("%0t covariance: expected %0d actual %0d",
                     $time, want.covariance, got.covariance);
            mismatches++;
         end
         if (got.sample_count !== want.sample_count) begin
            $display("%0t sample_count: expected %0d actual %0d",
                     $time, want.sample_count, got.sample_count);
            mismatches++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t overflow: expected %0b actual %0b",
                     $time, want.overflow, got.overflow);
            mismatches++;
         end
      endfunction
   endclass

   covariance_scoreboard_type sb = new();

   paired_sample_covariance_unit #(
      .MAX_SAMPLES(MAX_PAIRS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
      psc_req_type item;
      item.sample_x = x;
      item.sample_y = y;
      item.last     = last;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.accumulate_pair(item);
   endtask

   task automatic pause_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_covariances.size() != 0);
   endtask

   function automatic logic signed [15:0] pick_sample(sample_style_type style);
      case (style)
         FULL_RANGE: return 16'($urandom);
         EXTREMES: begin
            case ($urandom_range(0, 3))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         default: return 16'($urandom_range(0, 8)) - 16'd4;
      endcase
   endfunction

   task automatic send_set(input int unsigned length, input sample_style_type style);
      for (int i = 1; i <= length; i++)
         send_pair(pick_sample(style), pick_sample(style), i == length);
   endtask

   task automatic random_sets(input int unsigned item_budget);
      int unsigned sent;
      int unsigned length;
      int unsigned roll;
      sent = 0;
      while (sent < item_budget) begin
         roll = $urandom_range(0, 9);
         if (roll < 7) begin
            length = $urandom_range(1, 4);
         end else if (roll < 9) begin
            length = $urandom_range(5, 24);
         end else begin
            length = $urandom_range(25, 100);
         end
         send_set(length, sample_style_type'($urandom_range(0, 2)));
         sent += length;
      end
   endtask

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned long_length;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // single pair and two-pair sets, opposite extremes
      send_pair(-16'sd32768, 16'sd32767, 1'b1);
      send_pair(-16'sd32768, -16'sd32768, 1'b0);
      send_pair(16'sd32767, 16'sd32767, 1'b1);
      send_pair(-16'sd32768, 16'sd32767, 1'b0);
      send_pair(16'sd32767, -16'sd32768, 1'b1);
      // constant samples, then small values around zero
      send_pair(16'sd32767, 16'sd32767, 1'b0);
      send_pair(16'sd32767, 16'sd32767, 1'b0);
      send_pair(16'sd32767, 16'sd32767, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd0, -16'sd1, 1'b0);
      send_pair(-16'sd1, 16'sd0, 1'b0);
      send_pair(-16'sd1, -16'sd1, 1'b1);
      // small negative quotient truncates toward zero
      send_pair(16'sd1, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd1, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd2, 16'sd2, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sh5555, 16'shaaaa, 1'b0);
      send_pair(16'shaaaa, 16'sh5555, 1'b1);
      pause_for_results();

      random_sets(135);

      send_idle_pct = 80;
      recv_idle_pct = 30;
      // oversized set at the negative extreme, pairs beyond MAX_PAIRS dropped
      long_length = MAX_PAIRS + $urandom_range(1, 4);
      for (int i = 1; i <= long_length; i++)
         send_pair(-16'sd32768, -16'sd32768, i == long_length);
      random_sets(135);
      pause_for_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_sets(135);
      req_valid <= 1'b0;

      while (sb.expected_covariances.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_covariances.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
